[hw/rtl/hpt_pkg.sv]
// shared constants and types for the homogeneous point transform
package hpt_pkg;

  localparam int IN_W            = 32;
  localparam int ACT_W           = 2;
  localparam int IDX_W           = 4;
  localparam int MAT_N           = 16;
  localparam int ROWS            = 4;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_POINT  = 2'd1,
    ACT_VECTOR = 2'd2
  } act_t;

endpackage

[hw/rtl/hpt_in_if.sv]
// request channel into the transform
interface hpt_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [hpt_pkg::ACT_W-1:0]              action;
  logic [hpt_pkg::IDX_W-1:0]              entry_index;
  logic signed [hpt_pkg::IN_W-1:0]        entry_value;
  logic signed [hpt_pkg::IN_W-1:0]        coord_x;
  logic signed [hpt_pkg::IN_W-1:0]        coord_y;
  logic signed [hpt_pkg::IN_W-1:0]        coord_z;

  modport source (output valid, action, entry_index, entry_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, action, entry_index, entry_value, coord_x, coord_y, coord_z,
                output ready);
endinterface

[hw/rtl/hpt_out_if.sv]
// result channel out of the transform
interface hpt_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [hpt_pkg::IN_W-1:0] out_x;
  logic signed [hpt_pkg::IN_W-1:0] out_y;
  logic signed [hpt_pkg::IN_W-1:0] out_z;
  logic                            divided;
  logic                            saturated;

  modport source (output valid, out_x, out_y, out_z, divided, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, divided, saturated, output ready);
endinterface

[hw/rtl/hpt_row_lane.sv]
// one matrix row: three products, then sum, shift back and saturate
module hpt_row_lane #(
  parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [hpt_pkg::IN_W-1:0]   ent [4],
  input  logic signed [hpt_pkg::IN_W-1:0]   coord [3],
  input  logic                              point,
  output logic signed [COORD_WIDTH-1:0]     row_o,
  output logic                              clip_o
);
  import hpt_pkg::*;

  localparam int PW = 2 * IN_W;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [PW-1:0]          prod_r [3];
  logic signed [IN_W-1:0]        tr_r;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          shf;
  logic signed [COORD_WIDTH-1:0] row_nxt;
  logic                          clip_nxt;
  logic signed [COORD_WIDTH-1:0] row_r;
  logic                          clip_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= PW'(ent[i]) * PW'(coord[i]);
      end
      tr_r <= point ? ent[3] : '0;
    end
  end

  always_comb begin
    sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + (SW'(tr_r) <<< FRAC_BITS);
    shf = sum >>> FRAC_BITS;
    if (shf > MAXV) begin
      row_nxt  = COORD_WIDTH'(MAXV);
      clip_nxt = 1'b1;
    end else if (shf < MINV) begin
      row_nxt  = COORD_WIDTH'(MINV);
      clip_nxt = 1'b1;
    end else begin
      row_nxt  = COORD_WIDTH'(shf);
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      row_r  <= row_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign row_o  = row_r;
  assign clip_o = clip_r;
endmodule

[hw/rtl/hpt_div_lane.sv]
// pipelined restoring divide of one coordinate by w, one quotient bit per stage
module hpt_div_lane #(
  parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
  parameter int NQ          = COORD_WIDTH + FRAC_BITS
) (
  input  logic                          clk,
  input  logic [NQ:0]                   en,
  input  logic signed [COORD_WIDTH-1:0] c,
  input  logic signed [COORD_WIDTH-1:0] w,
  output logic signed [COORD_WIDTH-1:0] q_o,
  output logic signed [COORD_WIDTH-1:0] c_o,
  output logic                          clip_o
);
  localparam int CW = COORD_WIDTH;
  localparam logic [NQ-1:0] MAXQ = (NQ'(1) << (CW - 1)) - NQ'(1);
  localparam logic [NQ-1:0] MINQ = NQ'(1) << (CW - 1);

  logic [CW-1:0]        rem_r [NQ];
  logic [CW-1:0]        d_r   [NQ];
  logic [NQ-1:0]        nq_r  [NQ+1];
  logic                 sg_r  [NQ+1];
  logic signed [CW-1:0] c_r   [NQ+1];
  logic [CW-1:0]        cmag;
  logic [CW-1:0]        wmag;
  logic [NQ-1:0]        qv;

  assign cmag = c[CW-1] ? CW'(-c) : CW'(c);
  assign wmag = w[CW-1] ? CW'(-w) : CW'(w);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= '0;
      d_r[0]   <= wmag;
      nq_r[0]  <= NQ'(cmag) << FRAC_BITS;
      sg_r[0]  <= c[CW-1] ^ w[CW-1];
      c_r[0]   <= c;
    end
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_step
    logic [CW:0] sh;
    logic [CW:0] diff;
    logic        ge;
    assign sh   = {rem_r[k-1], nq_r[k-1][NQ-1]};
    assign diff = sh - {1'b0, d_r[k-1]};
    assign ge   = sh >= {1'b0, d_r[k-1]};
    always_ff @(posedge clk) begin
      if (en[k]) begin
        nq_r[k] <= {nq_r[k-1][NQ-2:0], ge};
        sg_r[k] <= sg_r[k-1];
        c_r[k]  <= c_r[k-1];
      end
    end
    if (k < NQ) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= ge ? diff[CW-1:0] : sh[CW-1:0];
          d_r[k]   <= d_r[k-1];
        end
      end
    end
  end

  assign qv = nq_r[NQ];

  always_comb begin
    if (!sg_r[NQ]) begin
      clip_o = qv > MAXQ;
      q_o    = clip_o ? {1'b0, {(CW-1){1'b1}}} : CW'(qv);
    end else begin
      clip_o = qv > MINQ;
      q_o    = clip_o ? {1'b1, {(CW-1){1'b0}}} : CW'(-qv);
    end
  end

  assign c_o = c_r[NQ];
endmodule

[hw/rtl/homogeneous_point_transform.sv]
// top level: four row lanes, w test, three divide lanes and the merging output register
// path: product, row, divide input and divide step registers, then the output register
// throughput: one request per cycle while the input is not stalled; loads give no result
// a waiting result lets empty stages fill behind it and stalls the input once all are full
// reset: the matrix returns to identity and all stage valid flags clear
module homogeneous_point_transform #(
  parameter int FRAC_BITS   = hpt_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hpt_in_if.sink     in_ch,
  hpt_out_if.source  out_ch
);
  import hpt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NQ = COORD_WIDTH + FRAC_BITS;
  localparam int NS = NQ + 4;
  localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;
  localparam logic signed [IN_W-1:0] ONE_E = IN_W'(1) <<< FRAC_BITS;

  logic [NS:0]           en;
  logic [NS-1:0]         v_r;
  logic signed [IN_W-1:0] mat_r [MAT_N];
  logic [1:0]            pt_r;
  logic [NQ:0]           dv_r;
  logic [NQ:0]           st_r;
  logic                  acc;
  logic                  item;
  logic signed [IN_W-1:0] coord [3];
  logic signed [IN_W-1:0] ent [ROWS][4];
  logic signed [CW-1:0]  row [ROWS];
  logic [ROWS-1:0]       rclip;
  logic signed [CW-1:0]  q [3];
  logic signed [CW-1:0]  cp [3];
  logic [2:0]            qclip;
  logic signed [IN_W-1:0] out_r [3];
  logic                  div_r;
  logic                  sat_r;

  always_comb begin
    en[NS] = out_ch.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];
  assign acc  = in_ch.valid && en[0];
  assign item = acc && (in_ch.action == ACT_POINT || in_ch.action == ACT_VECTOR);

  assign coord[0] = in_ch.coord_x;
  assign coord[1] = in_ch.coord_y;
  assign coord[2] = in_ch.coord_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      for (int i = 0; i < MAT_N; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ONE_E : '0;
      end
    end else begin
      if (en[0]) v_r[0] <= item;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
      if (acc && in_ch.action == ACT_LOAD) begin
        mat_r[in_ch.entry_index] <= in_ch.entry_value;
      end
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_ent
      assign ent[r][j] = mat_r[4*r + j];
    end
    hpt_row_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_row (
      .clk    (clk),
      .en     (en[1:0]),
      .ent    (ent[r]),
      .coord  (coord),
      .point  (in_ch.action == ACT_POINT),
      .row_o  (row[r]),
      .clip_o (rclip[r])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    hpt_div_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .NQ(NQ)) u_div (
      .clk    (clk),
      .en     (en[NQ+2:2]),
      .c      (row[i]),
      .w      (row[3]),
      .q_o    (q[i]),
      .c_o    (cp[i]),
      .clip_o (qclip[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en[0]) pt_r[0] <= in_ch.action == ACT_POINT;
    if (en[1]) pt_r[1] <= pt_r[0];
    if (en[2]) begin
      dv_r[0] <= pt_r[1] && row[3] != '0 && row[3] != ONE;
      st_r[0] <= |rclip[2:0] || (pt_r[1] && rclip[3]);
    end
    for (int j = 1; j <= NQ; j++) begin
      if (en[j+2]) begin
        dv_r[j] <= dv_r[j-1];
        st_r[j] <= st_r[j-1];
      end
    end
    // merge the lanes into one result
    if (en[NS-1]) begin
      for (int i = 0; i < 3; i++) begin
        out_r[i] <= IN_W'(dv_r[NQ] ? q[i] : cp[i]);
      end
      div_r <= dv_r[NQ];
      sat_r <= st_r[NQ] || (dv_r[NQ] && |qclip);
    end
  end

  assign out_ch.valid     = v_r[NS-1];
  assign out_ch.out_x     = out_r[0];
  assign out_ch.out_y     = out_r[1];
  assign out_ch.out_z     = out_r[2];
  assign out_ch.divided   = div_r;
  assign out_ch.saturated = sat_r;

  a_item_enters: assert property (@(posedge clk) disable iff (!rst_n)
    item |=> v_r[0]) else $error("transform request not captured");

  a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.action == ACT_LOAD |=> !v_r[0]) else $error("load created a result");

  a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.action == ACT_LOAD |=>
      mat_r[$past(in_ch.entry_index)] == $past(in_ch.entry_value))
    else $error("matrix entry not written");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> &v_r) else $error("request refused with an empty stage");
endmodule
